/* src/hsfd_pkg.sv */
package hsfd_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam int POS_W = 3;
  localparam logic [POS_W-1:0] POS_T_HI  = 3'd0;
  localparam logic [POS_W-1:0] POS_T_LO  = 3'd1;
  localparam logic [POS_W-1:0] POS_T_CRC = 3'd2;
  localparam logic [POS_W-1:0] POS_H_HI  = 3'd3;
  localparam logic [POS_W-1:0] POS_H_LO  = 3'd4;
  localparam logic [POS_W-1:0] POS_H_CRC = 3'd5;

  localparam logic KIND_DATA     = 1'b0;
  localparam logic KIND_BUS_FAIL = 1'b1;

  typedef enum logic [1:0] {
    CAUSE_NONE = 2'd0,
    CAUSE_BUS  = 2'd1,
    CAUSE_CRC  = 2'd2
  } cause_t;

  localparam logic [15:0] TEMP_SCALE  = 16'd17500;
  localparam logic [15:0] TEMP_OFFSET = 16'd4500;
  localparam logic [15:0] HUM_SCALE   = 16'd10000;
  localparam logic [16:0] FULL_SCALE  = 17'd65535;

  // one byte through the CRC-8, MSB first
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // floor(x / 65535): x = a*2^16 + b = a*65535 + (a + b)
  function automatic logic [16:0] div_full_scale(input logic [31:0] x);
    logic [16:0] s;
    logic [16:0] q;
    s = {1'b0, x[31:16]} + {1'b0, x[15:0]};
    q = {1'b0, x[31:16]};
    if (s >= FULL_SCALE) begin
      q = q + 17'd1;
    end
    if (s >= {FULL_SCALE[15:0], 1'b0}) begin
      q = q + 17'd1;
    end
    return q;
  endfunction

endpackage

/* src/humidity_sensor_frame_decode_core.sv */
// channel | ports                                   | dir
// in      | in_valid, in_stall, in_kind, in_data_byte | data byte or bus failure
// out     | out_valid, out_stall, out_ok, out_fail_cause,
//         | out_temperature_centi, out_humidity_centi,
//         | out_failure_total                      | one result per frame or failure
// One transfer per cycle unless a held result stalls; an input and a result register.
// The frame CRC check and both scalings are combinational between those registers.
// Synchronous active-low reset clears frame position, tally, valid flags; presets the CRC.
// A held result stalls only items that produce a result; frame bytes keep flowing.
module humidity_sensor_frame_decode_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_kind,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_ok,
  output logic [1:0]         out_fail_cause,
  output logic signed [14:0] out_temperature_centi,
  output logic [13:0]        out_humidity_centi,
  output logic [31:0]        out_failure_total
);

  logic                          in_q_valid_r, in_q_valid_nxt;
  logic                          in_q_kind_r;
  logic [7:0]                    in_q_byte_r;

  logic [hsfd_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic [7:0]                    crc_r, crc_nxt;
  logic                          first_good_r, first_good_nxt;
  logic [7:0]                    high_byte_r, high_byte_nxt;
  logic [15:0]                   temp_word_r, temp_word_nxt;
  logic [15:0]                   hum_word_r, hum_word_nxt;
  logic [31:0]                   tally_r, tally_nxt;

  logic                          out_valid_r;
  logic                          out_ok_r, out_ok_nxt;
  hsfd_pkg::cause_t              out_cause_r, out_cause_nxt;
  logic signed [14:0]            out_temp_r, out_temp_nxt;
  logic [13:0]                   out_hum_r, out_hum_nxt;

  logic [hsfd_pkg::POS_W-1:0]    pos_eff;
  logic [7:0]                    crc_step;
  logic                          emits;
  logic                          slot_free;
  logic                          fire;
  logic                          frame_good;
  logic signed [14:0]            scaled_temp;
  logic [13:0]                   scaled_hum;

  hsfd_scale u_scale (
    .temperature_word  (temp_word_r),
    .humidity_word     (hum_word_r),
    .temperature_centi (scaled_temp),
    .humidity_centi    (scaled_hum)
  );

  assign pos_eff   = (pos_r > hsfd_pkg::POS_H_CRC) ? hsfd_pkg::POS_T_HI : pos_r;
  assign emits     = (in_q_kind_r == hsfd_pkg::KIND_BUS_FAIL) ||
                     (pos_eff == hsfd_pkg::POS_H_CRC);
  assign slot_free = !out_valid_r || !out_stall;
  assign fire      = in_q_valid_r && (!emits || slot_free);
  assign in_stall  = in_q_valid_r && !fire;
  assign crc_step  = hsfd_pkg::crc_feed(crc_r, in_q_byte_r);
  assign frame_good = first_good_r && (crc_r == in_q_byte_r);

  always_comb begin
    pos_nxt        = pos_r;
    crc_nxt        = crc_r;
    first_good_nxt = first_good_r;
    high_byte_nxt  = high_byte_r;
    temp_word_nxt  = temp_word_r;
    hum_word_nxt   = hum_word_r;
    tally_nxt      = tally_r;
    out_ok_nxt     = 1'b0;
    out_cause_nxt  = hsfd_pkg::CAUSE_NONE;
    out_temp_nxt   = '0;
    out_hum_nxt    = '0;
    if (in_q_kind_r == hsfd_pkg::KIND_BUS_FAIL) begin
      tally_nxt     = tally_r + 32'd1;
      pos_nxt       = hsfd_pkg::POS_T_HI;
      crc_nxt       = hsfd_pkg::CRC_INIT;
      out_cause_nxt = hsfd_pkg::CAUSE_BUS;
    end else begin
      case (pos_eff)
        hsfd_pkg::POS_T_HI, hsfd_pkg::POS_H_HI: begin
          crc_nxt       = hsfd_pkg::crc_feed(hsfd_pkg::CRC_INIT, in_q_byte_r);
          high_byte_nxt = in_q_byte_r;
          pos_nxt       = pos_eff + 3'd1;
        end
        hsfd_pkg::POS_T_LO: begin
          crc_nxt       = crc_step;
          temp_word_nxt = {high_byte_r, in_q_byte_r};
          pos_nxt       = hsfd_pkg::POS_T_CRC;
        end
        hsfd_pkg::POS_T_CRC: begin
          first_good_nxt = (crc_r == in_q_byte_r);
          crc_nxt        = hsfd_pkg::CRC_INIT;
          pos_nxt        = hsfd_pkg::POS_H_HI;
        end
        hsfd_pkg::POS_H_LO: begin
          crc_nxt      = crc_step;
          hum_word_nxt = {high_byte_r, in_q_byte_r};
          pos_nxt      = hsfd_pkg::POS_H_CRC;
        end
        default: begin
          pos_nxt = hsfd_pkg::POS_T_HI;
          crc_nxt = hsfd_pkg::CRC_INIT;
          if (frame_good) begin
            out_ok_nxt   = 1'b1;
            out_temp_nxt = scaled_temp;
            out_hum_nxt  = scaled_hum;
          end else begin
            tally_nxt     = tally_r + 32'd1;
            out_cause_nxt = hsfd_pkg::CAUSE_CRC;
          end
        end
      endcase
    end
  end

  assign in_q_valid_nxt = in_stall ? in_q_valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_q_valid_r <= 1'b0;
      pos_r        <= hsfd_pkg::POS_T_HI;
      crc_r        <= hsfd_pkg::CRC_INIT;
      first_good_r <= 1'b0;
      high_byte_r  <= '0;
      temp_word_r  <= '0;
      hum_word_r   <= '0;
      tally_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      in_q_valid_r <= in_q_valid_nxt;
      if (fire) begin
        pos_r        <= pos_nxt;
        crc_r        <= crc_nxt;
        first_good_r <= first_good_nxt;
        high_byte_r  <= high_byte_nxt;
        temp_word_r  <= temp_word_nxt;
        hum_word_r   <= hum_word_nxt;
        tally_r      <= tally_nxt;
      end
      if (fire && emits) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_q_kind_r <= in_kind;
      in_q_byte_r <= in_data_byte;
    end
    if (fire && emits) begin
      out_ok_r    <= out_ok_nxt;
      out_cause_r <= out_cause_nxt;
      out_temp_r  <= out_temp_nxt;
      out_hum_r   <= out_hum_nxt;
    end
  end

  logic [31:0] out_tally_r;

  always_ff @(posedge clk) begin
    if (fire && emits) begin
      out_tally_r <= tally_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_ok                = out_ok_r;
  assign out_fail_cause        = out_cause_r;
  assign out_temperature_centi = out_temp_r;
  assign out_humidity_centi    = out_hum_r;
  assign out_failure_total     = out_tally_r;

  a_ok_no_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_ok_r == (out_cause_r == hsfd_pkg::CAUSE_NONE)))
    else $error("ok flag and fail cause disagree");

  a_tally_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((tally_r == $past(tally_r)) || (tally_r == $past(tally_r) + 32'd1)))
    else $error("failure tally moved by more than one");

  a_result_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !(fire && emits))
    else $error("result overwritten while held");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_q_valid_r && emits && out_valid_r))
    else $error("input stalled without a held result");

endmodule

/* src/hsfd_scale.sv */
module hsfd_scale (
  input  logic [15:0]        temperature_word,
  input  logic [15:0]        humidity_word,
  output logic signed [14:0] temperature_centi,
  output logic [13:0]        humidity_centi
);

  logic [31:0]        t_prod;
  logic [31:0]        h_prod;
  logic [16:0]        t_quot;
  logic [16:0]        h_quot;
  logic signed [15:0] t_shift;

  assign t_prod = 32'(temperature_word) * 32'(hsfd_pkg::TEMP_SCALE);
  assign h_prod = 32'(humidity_word) * 32'(hsfd_pkg::HUM_SCALE);
  assign t_quot = hsfd_pkg::div_full_scale(t_prod);
  assign h_quot = hsfd_pkg::div_full_scale(h_prod);

  assign t_shift = $signed({1'b0, t_quot[14:0]}) - $signed(hsfd_pkg::TEMP_OFFSET);
  assign temperature_centi = t_shift[14:0];
  assign humidity_centi    = h_quot[13:0];

endmodule
